// File: hdl/circ_pkg.sv
// Shared widths, types and register map of the circumcircle block.
`timescale 1ns / 1ps

package circ_pkg;

    // Coordinate format and threshold.
    localparam int COORD_W    = 24;
    localparam int FRAC_W     = 8;
    localparam int THR_W      = 16;
    localparam int THR_UNIT_W = 16;

    // Front widths.
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DET_W  = PROD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int CMP_W  = DET_W + THR_UNIT_W;

    // Numerator widths: a square sum is split into two halves for the multipliers.
    localparam int HALF_W = SQ_W / 2;
    localparam int PP_W   = DIFF_W + HALF_W + 1;
    localparam int NUM_W  = DIFF_W + SQ_W + 1;

    // Divider widths.
    localparam int N_W       = NUM_W + 1;
    localparam int D_W       = DET_W + 1;
    localparam int CLAMP_SH  = 40;
    localparam int Q_W       = CLAMP_SH + 1;
    localparam int REM_W     = D_W + 1;
    localparam int NHI_W     = N_W - Q_W;
    localparam int DIV_LAT   = Q_W;

    // Centre and radius widths.
    localparam int U_W    = Q_W + 1;
    localparam int SUM_W  = U_W + 1;
    localparam int SQR_W  = 2 * COORD_W;
    localparam int S_W    = SQR_W + 1;
    localparam int ROOT_W = (S_W + 1) / 2;
    localparam int RR_W   = ROOT_W + 3;
    localparam int RAD_W  = ROOT_W + 1;
    localparam int ROOT_LAT = ROOT_W;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_COLL_THR = '0;
    localparam logic [THR_W-1:0]  THR_RESET    = 16'd1;

    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [DIFF_W-1:0]  ax;
        logic [DIFF_W-1:0]  ay;
        logic [DIFF_W-1:0]  bx;
        logic [DIFF_W-1:0]  by;
    } t_geo;

    typedef struct packed {
        t_geo             geo;
        logic             det_neg;
        logic [DET_W-1:0] det_abs;
        logic [SQ_W-1:0]  sa;
        logic [SQ_W-1:0]  sb;
        logic             coll;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: hdl/circ_front.sv
// Front pipeline: differences, products, determinant and collinear classification.
`timescale 1ns / 1ps

module circ_front import circ_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_x1,
    input  logic signed [COORD_W-1:0] i_y1,
    input  logic signed [COORD_W-1:0] i_x2,
    input  logic signed [COORD_W-1:0] i_y2,
    input  logic signed [COORD_W-1:0] i_x3,
    input  logic signed [COORD_W-1:0] i_y3,
    input  logic [THR_W-1:0]          i_thr,
    output logic                      o_valid,
    output t_item                     o_item
);

    logic r_v1, r_v2, r_v3, r_v4;
    t_geo n_geo, r_g1, r_g2, r_g3;
    logic signed [PROD_W-1:0] r_axby, r_aybx, r_axax, r_ayay, r_bxbx, r_byby;
    logic signed [DET_W-1:0]  r_det3;
    logic [SQ_W-1:0]          r_sa3, r_sb3;
    logic [DET_W-1:0]         n_det_abs;
    logic                     n_coll;
    t_item                    r_item4;

    always_comb begin
        n_geo.x1 = i_x1;
        n_geo.y1 = i_y1;
        n_geo.ax = DIFF_W'(i_x2) - DIFF_W'(i_x1);
        n_geo.ay = DIFF_W'(i_y2) - DIFF_W'(i_y1);
        n_geo.bx = DIFF_W'(i_x3) - DIFF_W'(i_x1);
        n_geo.by = DIFF_W'(i_y3) - DIFF_W'(i_y1);
    end

    // A zero determinant is collinear even with a zero threshold.
    always_comb begin
        n_det_abs = r_det3[DET_W-1] ? DET_W'(-r_det3) : DET_W'(r_det3);
        n_coll    = (r_det3 == '0) ||
                    ({n_det_abs, {THR_UNIT_W{1'b0}}} <
                     CMP_W'({i_thr, {(2 * FRAC_W){1'b0}}}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g1   <= n_geo;
            r_g2   <= r_g1;
            r_axby <= $signed(r_g1.ax) * $signed(r_g1.by);
            r_aybx <= $signed(r_g1.ay) * $signed(r_g1.bx);
            r_axax <= $signed(r_g1.ax) * $signed(r_g1.ax);
            r_ayay <= $signed(r_g1.ay) * $signed(r_g1.ay);
            r_bxbx <= $signed(r_g1.bx) * $signed(r_g1.bx);
            r_byby <= $signed(r_g1.by) * $signed(r_g1.by);
            r_g3   <= r_g2;
            r_det3 <= DET_W'(r_axby) - DET_W'(r_aybx);
            r_sa3  <= SQ_W'(r_axax) + SQ_W'(r_ayay);
            r_sb3  <= SQ_W'(r_bxbx) + SQ_W'(r_byby);
            r_item4.geo     <= r_g3;
            r_item4.det_neg <= r_det3[DET_W-1];
            r_item4.det_abs <= n_det_abs;
            r_item4.sa      <= r_sa3;
            r_item4.sb      <= r_sb3;
            r_item4.coll    <= n_coll;
        end
    end

    assign o_valid = r_v4;
    assign o_item  = r_item4;

endmodule

// File: hdl/circ_queue.sv
// Short queue of classified items between the front and the back.
`timescale 1ns / 1ps

module circ_queue import circ_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count, n_count;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd];
    assign o_status.full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// File: hdl/circ_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a quotient overflow check.
`timescale 1ns / 1ps

module circ_div import circ_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [N_W-1:0] i_n,
    input  logic [D_W-1:0] i_d,
    output logic [Q_W-1:0] o_q,
    output logic           o_ovf
);

    logic [REM_W-1:0] r_rem [DIV_LAT];
    logic [Q_W-1:0]   r_nl  [DIV_LAT];
    logic [D_W-1:0]   r_d   [DIV_LAT];
    logic [Q_W-1:0]   r_q   [DIV_LAT];
    logic             r_ovf [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
        logic [REM_W-1:0] rem_in, rem_sh, n_rem;
        logic [Q_W-1:0]   nl_in, q_in;
        logic [D_W-1:0]   d_in;
        logic             ovf_in, ge;

        if (k == 0) begin : g_first
            // The quotient fits in Q_W bits only if the high part of n is below d.
            assign rem_in = REM_W'(i_n[N_W-1:Q_W]);
            assign nl_in  = i_n[Q_W-1:0];
            assign d_in   = i_d;
            assign q_in   = '0;
            assign ovf_in = (D_W'(i_n[N_W-1:Q_W]) >= i_d);
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign nl_in  = r_nl[k-1];
            assign d_in   = r_d[k-1];
            assign q_in   = r_q[k-1];
            assign ovf_in = r_ovf[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-2:0], nl_in[Q_W-1]};
            ge     = (rem_sh >= {1'b0, d_in});
            n_rem  = ge ? (rem_sh - {1'b0, d_in}) : rem_sh;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_nl[k]  <= {nl_in[Q_W-2:0], 1'b0};
                r_d[k]   <= d_in;
                r_q[k]   <= {q_in[Q_W-2:0], ge};
                r_ovf[k] <= ovf_in;
            end
        end
    end

    assign o_q   = r_q[DIV_LAT-1];
    assign o_ovf = r_ovf[DIV_LAT-1];

endmodule

// File: hdl/circ_root.sv
// Pipelined integer square root, one root bit per stage, keeping the remainder.
`timescale 1ns / 1ps

module circ_root import circ_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [S_W-1:0]    i_s,
    output logic [ROOT_W-1:0] o_root,
    output logic [RR_W-1:0]   o_rem
);

    logic [ROOT_W-1:0]   r_r   [ROOT_LAT];
    logic [RR_W-1:0]     r_rem [ROOT_LAT];
    logic [2*ROOT_W-1:0] r_sh  [ROOT_LAT];

    for (genvar k = 0; k < ROOT_LAT; k++) begin : g_stage
        logic [ROOT_W-1:0]   r_in;
        logic [RR_W-1:0]     rem_in, rem_sh, trial, n_rem;
        logic [2*ROOT_W-1:0] sh_in;
        logic                ge;

        if (k == 0) begin : g_first
            assign r_in   = '0;
            assign rem_in = '0;
            assign sh_in  = (2 * ROOT_W)'(i_s);
        end else begin : g_next
            assign r_in   = r_r[k-1];
            assign rem_in = r_rem[k-1];
            assign sh_in  = r_sh[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[RR_W-3:0], sh_in[2*ROOT_W-1 -: 2]};
            trial  = {1'b0, r_in, 2'b01};
            ge     = (rem_sh >= trial);
            n_rem  = ge ? (rem_sh - trial) : rem_sh;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k]   <= {r_in[ROOT_W-2:0], ge};
                r_rem[k] <= n_rem;
                r_sh[k]  <= {sh_in[2*ROOT_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_r[ROOT_LAT-1];
    assign o_rem  = r_rem[ROOT_LAT-1];

endmodule

// File: hdl/circ_back.sv
// Back pipeline: numerators, offset division, centre saturation, radius and result register.
`timescale 1ns / 1ps

module circ_back import circ_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_item              i_item,
    input  t_q_status          i_q_status,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_valid,
    output logic [COORD_W-1:0] o_center_x,
    output logic [COORD_W-1:0] o_center_y,
    output logic [COORD_W-1:0] o_radius,
    output logic               o_collinear,
    output logic               o_overflow
);

    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic               sgnx;
        logic               sgny;
        logic               coll;
    } t_dside;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic               sat;
        logic               big;
        logic               coll;
    } t_rside;

    logic en;

    // Numerator stages.
    logic  r_b1_v, r_b2_v, r_b3_v, r_b4_v, r_b5_v;
    t_item r_b1, r_b2, r_b3, r_b4;
    logic signed [PP_W-1:0]  r_pp_bysa_lo, r_pp_bysa_hi, r_pp_aysb_lo, r_pp_aysb_hi;
    logic signed [PP_W-1:0]  r_pp_axsb_lo, r_pp_axsb_hi, r_pp_bxsa_lo, r_pp_bxsa_hi;
    logic signed [NUM_W-1:0] r_pr_bysa, r_pr_aysb, r_pr_axsb, r_pr_bxsa;
    logic signed [NUM_W-1:0] r_numx, r_numy;
    logic [NUM_W-1:0]        n_absx, n_absy;
    logic [N_W-1:0]          r_nx, r_ny;
    logic [D_W-1:0]          r_d;
    t_dside                  r_b5_side;

    // Division.
    logic [Q_W-1:0] qx, qy;
    logic           ovfx, ovfy;
    logic           r_dv [DIV_LAT];
    t_dside         r_ds [DIV_LAT];

    // Centre and square sum.
    logic               r_c1_v, r_c2_v, r_c3_v;
    logic [Q_W-1:0]     r_c1_magx, r_c1_magy;
    t_dside             r_c1_side, r_c2_side;
    logic signed [U_W-1:0] r_c2_ux, r_c2_uy;
    logic               r_c2_big;
    logic [SQR_W-1:0]   r_c2_sqx, r_c2_sqy;
    logic signed [SUM_W-1:0] n_sumx, n_sumy;
    logic [COORD_W-1:0] n_cx, n_cy;
    logic               n_satx, n_saty;
    t_rside             r_c3_side;
    logic [S_W-1:0]     r_c3_s;

    // Root.
    logic [ROOT_W-1:0] root;
    logic [RR_W-1:0]   root_rem;
    logic              r_rv [ROOT_LAT];
    t_rside            r_rs [ROOT_LAT];
    logic [RAD_W-1:0]  n_rad;
    logic              n_radbig;

    // Result register.
    logic               r_out_v;
    logic [COORD_W-1:0] r_out_cx, r_out_cy, r_out_rad;
    logic               r_out_coll, r_out_ovf;

    assign en      = !r_out_v || i_pop;
    assign o_q_pop = en && !i_q_status.empty;

    function automatic logic [Q_W-1:0] clamp_mag(input logic [Q_W-1:0] q, input logic ovf);
        logic big;
        big = ovf || (q[Q_W-1] && (q[Q_W-2:0] != '0));
        return big ? {1'b1, {(Q_W - 1){1'b0}}} : q;
    endfunction

    always_comb begin
        n_absx = r_numx[NUM_W-1] ? NUM_W'(-r_numx) : NUM_W'(r_numx);
        n_absy = r_numy[NUM_W-1] ? NUM_W'(-r_numy) : NUM_W'(r_numy);
    end

    // Centre: saturate to the signed coordinate range.
    always_comb begin
        n_sumx = SUM_W'($signed(r_c2_side.x1)) + SUM_W'(r_c2_ux);
        n_sumy = SUM_W'($signed(r_c2_side.y1)) + SUM_W'(r_c2_uy);
        n_satx = !((n_sumx[SUM_W-1:COORD_W-1] == '0) || (n_sumx[SUM_W-1:COORD_W-1] == '1));
        n_saty = !((n_sumy[SUM_W-1:COORD_W-1] == '0) || (n_sumy[SUM_W-1:COORD_W-1] == '1));
        n_cx   = n_sumx[COORD_W-1:0];
        n_cy   = n_sumy[COORD_W-1:0];
        if (n_satx) begin
            n_cx = n_sumx[SUM_W-1] ? {1'b1, {(COORD_W - 1){1'b0}}}
                                   : {1'b0, {(COORD_W - 1){1'b1}}};
        end
        if (n_saty) begin
            n_cy = n_sumy[SUM_W-1] ? {1'b1, {(COORD_W - 1){1'b0}}}
                                   : {1'b0, {(COORD_W - 1){1'b1}}};
        end
    end

    // Radius: round the floor root up when the remainder exceeds the root.
    always_comb begin
        n_rad    = (root_rem > RR_W'(root)) ? (RAD_W'(root) + 1'b1) : RAD_W'(root);
        n_radbig = r_rs[ROOT_LAT-1].big || (n_rad[RAD_W-1:COORD_W] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_b2_v  <= 1'b0;
            r_b3_v  <= 1'b0;
            r_b4_v  <= 1'b0;
            r_b5_v  <= 1'b0;
            r_c1_v  <= 1'b0;
            r_c2_v  <= 1'b0;
            r_c3_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dv[i] <= 1'b0;
            end
            for (int i = 0; i < ROOT_LAT; i++) begin
                r_rv[i] <= 1'b0;
            end
        end else if (en) begin
            r_b1_v  <= !i_q_status.empty;
            r_b2_v  <= r_b1_v;
            r_b3_v  <= r_b2_v;
            r_b4_v  <= r_b3_v;
            r_b5_v  <= r_b4_v;
            r_dv[0] <= r_b5_v;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            r_c1_v  <= r_dv[DIV_LAT-1];
            r_c2_v  <= r_c1_v;
            r_c3_v  <= r_c2_v;
            r_rv[0] <= r_c3_v;
            for (int i = 1; i < ROOT_LAT; i++) begin
                r_rv[i] <= r_rv[i-1];
            end
            r_out_v <= r_rv[ROOT_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1 <= i_item;

            r_b2 <= r_b1;
            r_pp_bysa_lo <= $signed(r_b1.geo.by) * $signed({1'b0, r_b1.sa[HALF_W-1:0]});
            r_pp_bysa_hi <= $signed(r_b1.geo.by) * $signed({1'b0, r_b1.sa[SQ_W-1:HALF_W]});
            r_pp_aysb_lo <= $signed(r_b1.geo.ay) * $signed({1'b0, r_b1.sb[HALF_W-1:0]});
            r_pp_aysb_hi <= $signed(r_b1.geo.ay) * $signed({1'b0, r_b1.sb[SQ_W-1:HALF_W]});
            r_pp_axsb_lo <= $signed(r_b1.geo.ax) * $signed({1'b0, r_b1.sb[HALF_W-1:0]});
            r_pp_axsb_hi <= $signed(r_b1.geo.ax) * $signed({1'b0, r_b1.sb[SQ_W-1:HALF_W]});
            r_pp_bxsa_lo <= $signed(r_b1.geo.bx) * $signed({1'b0, r_b1.sa[HALF_W-1:0]});
            r_pp_bxsa_hi <= $signed(r_b1.geo.bx) * $signed({1'b0, r_b1.sa[SQ_W-1:HALF_W]});

            r_b3 <= r_b2;
            r_pr_bysa <= (NUM_W'(r_pp_bysa_hi) <<< HALF_W) + NUM_W'(r_pp_bysa_lo);
            r_pr_aysb <= (NUM_W'(r_pp_aysb_hi) <<< HALF_W) + NUM_W'(r_pp_aysb_lo);
            r_pr_axsb <= (NUM_W'(r_pp_axsb_hi) <<< HALF_W) + NUM_W'(r_pp_axsb_lo);
            r_pr_bxsa <= (NUM_W'(r_pp_bxsa_hi) <<< HALF_W) + NUM_W'(r_pp_bxsa_lo);

            r_b4   <= r_b3;
            r_numx <= r_pr_bysa - r_pr_aysb;
            r_numy <= r_pr_axsb - r_pr_bxsa;

            // Rounded quotient: (|n| + |d|) / (2|d|).
            r_nx <= N_W'(n_absx) + N_W'(r_b4.det_abs);
            r_ny <= N_W'(n_absy) + N_W'(r_b4.det_abs);
            r_d  <= {r_b4.det_abs, 1'b0};
            r_b5_side.x1   <= r_b4.geo.x1;
            r_b5_side.y1   <= r_b4.geo.y1;
            r_b5_side.sgnx <= r_numx[NUM_W-1] ^ r_b4.det_neg;
            r_b5_side.sgny <= r_numy[NUM_W-1] ^ r_b4.det_neg;
            r_b5_side.coll <= r_b4.coll;

            r_ds[0] <= r_b5_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_ds[i] <= r_ds[i-1];
            end

            r_c1_magx <= clamp_mag(qx, ovfx);
            r_c1_magy <= clamp_mag(qy, ovfy);
            r_c1_side <= r_ds[DIV_LAT-1];

            r_c2_side <= r_c1_side;
            r_c2_ux   <= r_c1_side.sgnx ? -U_W'(r_c1_magx) : U_W'(r_c1_magx);
            r_c2_uy   <= r_c1_side.sgny ? -U_W'(r_c1_magy) : U_W'(r_c1_magy);
            r_c2_big  <= (r_c1_magx[Q_W-1:COORD_W] != '0) || (r_c1_magy[Q_W-1:COORD_W] != '0);
            r_c2_sqx  <= r_c1_magx[COORD_W-1:0] * r_c1_magx[COORD_W-1:0];
            r_c2_sqy  <= r_c1_magy[COORD_W-1:0] * r_c1_magy[COORD_W-1:0];

            r_c3_side.cx   <= n_cx;
            r_c3_side.cy   <= n_cy;
            r_c3_side.sat  <= n_satx || n_saty;
            r_c3_side.big  <= r_c2_big;
            r_c3_side.coll <= r_c2_side.coll;
            r_c3_s         <= S_W'(r_c2_sqx) + S_W'(r_c2_sqy);

            r_rs[0] <= r_c3_side;
            for (int i = 1; i < ROOT_LAT; i++) begin
                r_rs[i] <= r_rs[i-1];
            end

            if (r_rs[ROOT_LAT-1].coll) begin
                r_out_cx   <= '0;
                r_out_cy   <= '0;
                r_out_rad  <= '0;
                r_out_coll <= 1'b1;
                r_out_ovf  <= 1'b0;
            end else begin
                r_out_cx   <= r_rs[ROOT_LAT-1].cx;
                r_out_cy   <= r_rs[ROOT_LAT-1].cy;
                r_out_rad  <= n_radbig ? {COORD_W{1'b1}} : n_rad[COORD_W-1:0];
                r_out_coll <= 1'b0;
                r_out_ovf  <= r_rs[ROOT_LAT-1].sat || n_radbig;
            end
        end
    end

    circ_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (r_nx),
        .i_d   (r_d),
        .o_q   (qx),
        .o_ovf (ovfx)
    );

    circ_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (r_ny),
        .i_d   (r_d),
        .o_q   (qy),
        .o_ovf (ovfy)
    );

    circ_root u_root (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    (r_c3_s),
        .o_root (root),
        .o_rem  (root_rem)
    );

    assign o_valid     = r_out_v;
    assign o_center_x  = r_out_cx;
    assign o_center_y  = r_out_cy;
    assign o_radius    = r_out_rad;
    assign o_collinear = r_out_coll;
    assign o_overflow  = r_out_ovf;

endmodule

// File: hdl/circumcircle_from_three_points.sv
// Top level of the circumcircle block: request queue ports, threshold register, front and back.
`timescale 1ns / 1ps
// One request per cycle while full is low; the 41-stage offset dividers and the 25-stage
// square root each take one bit per stage and advance together, so a new request enters
// every cycle unless full holds the input off.
// Reset (synchronous, active low) empties every stage and the queue and sets the threshold to 1.

module circumcircle_from_three_points import circ_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request side.
    input  logic                      push,
    output logic                      full,
    input  logic signed [COORD_W-1:0] i_first_x,
    input  logic signed [COORD_W-1:0] i_first_y,
    input  logic signed [COORD_W-1:0] i_second_x,
    input  logic signed [COORD_W-1:0] i_second_y,
    input  logic signed [COORD_W-1:0] i_third_x,
    input  logic signed [COORD_W-1:0] i_third_y,
    // Result side.
    output logic                      empty,
    input  logic                      pop,
    output logic signed [COORD_W-1:0] o_center_x,
    output logic signed [COORD_W-1:0] o_center_y,
    output logic [COORD_W-1:0]        o_circle_radius,
    output logic                      o_collinear,
    output logic                      o_overflow,
    // Configuration port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    logic [THR_W-1:0] r_thr;
    logic             front_en, front_valid, q_push, q_pop, out_valid;
    t_item            front_item, q_item;
    t_q_status        q_status;
    logic [COORD_W-1:0] center_x, center_y;

    // The threshold register sits at byte addresses 0 to 3; addresses 4 to 7 read as zero
    // and ignore writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[ADDR_W-1:2] == REG_COLL_THR)) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_COLL_THR) ? DATA_W'(r_thr) : '0;

    // The front stalls as a whole only when its finished item cannot enter the queue,
    // so requests keep flowing while the back waits on the result side, until the queue fills.
    assign front_en = !front_valid || !q_status.full;
    assign q_push   = front_valid && !q_status.full;
    assign full     = !front_en;

    circ_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (front_en),
        .i_valid (push),
        .i_x1    (i_first_x),
        .i_y1    (i_first_y),
        .i_x2    (i_second_x),
        .i_y2    (i_second_y),
        .i_x3    (i_third_x),
        .i_y3    (i_third_y),
        .i_thr   (r_thr),
        .o_valid (front_valid),
        .o_item  (front_item)
    );

    circ_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (front_item),
        .i_pop    (q_pop),
        .o_item   (q_item),
        .o_status (q_status)
    );

    // The back advances whenever its result register is free or being emptied.
    circ_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_item),
        .i_q_status  (q_status),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_center_x  (center_x),
        .o_center_y  (center_y),
        .o_radius    (o_circle_radius),
        .o_collinear (o_collinear),
        .o_overflow  (o_overflow)
    );

    assign empty      = !out_valid;
    assign o_center_x = $signed(center_x);
    assign o_center_y = $signed(center_y);

endmodule

// File: sim/tb_circumcircle_from_three_points.sv
// Self-checking testbench for the circumcircle block: directed, random and back-pressure tests.
`timescale 1ns / 1ps

module tb_circumcircle_from_three_points import circ_pkg::*;;

    // One predicted result, typed at the widths of the result ports.
    typedef struct {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [COORD_W-1:0]        rad;
        logic                      coll;
        logic                      ovf;
    } t_circle;

    localparam longint CLAMP_MAG = longint'(1) << CLAMP_SH;
    localparam longint C_MAX     = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint C_MIN     = -(longint'(1) << (COORD_W - 1));
    localparam longint R_MAX     = (longint'(1) << COORD_W) - 1;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic signed [COORD_W-1:0] i_first_x, i_first_y, i_second_x, i_second_y;
    logic signed [COORD_W-1:0] i_third_x, i_third_y;
    logic                      empty;
    logic                      pop;
    logic signed [COORD_W-1:0] o_center_x, o_center_y;
    logic [COORD_W-1:0]        o_circle_radius;
    logic                      o_collinear, o_overflow;
    logic                      psel, penable, pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    t_circle     circles_due[$];
    logic [15:0] thr_copy;
    int          mismatches;
    bit          quiet;      // when set, neither side idles
    bit          hold_req;   // asks the result side for a long hold-off
    int          hold_left;

    circumcircle_from_three_points dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Safety net: far beyond the slowest legitimate run.
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Offset of the centre from the first point: num / (2*det), rounded half away from
    // zero, with its magnitude clamped before it can grow unreasonably.
    function automatic longint centre_offset(input logic signed [127:0] num,
                                             input logic signed [127:0] det);
        logic [127:0] an, ad, q;
        longint       mag;
        an = num < 0 ? -num : num;
        ad = det < 0 ? -det : det;
        q = (an + ad) / (ad << 1);
        mag = (q > 128'(CLAMP_MAG)) ? CLAMP_MAG : longint'(q);
        return ((num < 0) != (det < 0)) ? -mag : mag;
    endfunction

    function automatic t_circle predict_circle(input logic signed [COORD_W-1:0] x1, y1,
                                               input logic signed [COORD_W-1:0] x2, y2,
                                               input logic signed [COORD_W-1:0] x3, y3,
                                               input logic [15:0] thr);
        logic signed [127:0] ax, ay, bx, by, det, adet, sa, sb;
        longint              ux, uy, px, py;
        logic [63:0]         mx, my, s, r, t;
        t_circle             c;
        ax = x2 - x1;
        ay = y2 - y1;
        bx = x3 - x1;
        by = y3 - y1;
        det = ax * by - ay * bx;
        adet = det < 0 ? -det : det;
        c = '{cx: '0, cy: '0, rad: '0, coll: 1'b0, ovf: 1'b0};
        // Exactly zero is always collinear, even with a zero threshold.
        if (det == 0 || adet < $signed({112'd0, thr})) begin
            c.coll = 1'b1;
            return c;
        end
        sa = ax * ax + ay * ay;
        sb = bx * bx + by * by;
        ux = centre_offset(by * sa - ay * sb, det);
        uy = centre_offset(ax * sb - bx * sa, det);
        px = longint'(x1) + ux;
        py = longint'(y1) + uy;
        if (px > C_MAX) begin px = C_MAX; c.ovf = 1'b1; end
        if (px < C_MIN) begin px = C_MIN; c.ovf = 1'b1; end
        if (py > C_MAX) begin py = C_MAX; c.ovf = 1'b1; end
        if (py < C_MIN) begin py = C_MIN; c.ovf = 1'b1; end
        c.cx = px[COORD_W-1:0];
        c.cy = py[COORD_W-1:0];
        mx = ux < 0 ? -ux : ux;
        my = uy < 0 ? -uy : uy;
        if (mx > R_MAX || my > R_MAX) begin
            r = R_MAX;
            c.ovf = 1'b1;
        end else begin
            s = mx * mx + my * my;
            r = 0;
            // s stays below 2^49, so 32 root bits are plenty and t*t cannot wrap.
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= s) r = t;
            end
            if (s - r * r > r) r = r + 1;
            if (r > R_MAX) begin r = R_MAX; c.ovf = 1'b1; end
        end
        c.rad = r[COORD_W-1:0];
        return c;
    endfunction

    // Result side: random pops, an occasional long hold-off, and the check of each result.
    always @(posedge i_clk) begin
        t_circle e;
        if (!i_rst_n) begin
            pop <= 1'b0;
            hold_left = 0;
        end else begin
            if (pop && !empty) begin
                if (circles_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result: nothing was due");
                end else begin
                    e = circles_due.pop_front();
                    if (o_center_x !== e.cx || o_center_y !== e.cy
                        || o_circle_radius !== e.rad
                        || o_collinear !== e.coll || o_overflow !== e.ovf) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected c=(%0d,%0d) r=%0d col=%b ovf=%b,",
                                      " got c=(%0d,%0d) r=%0d col=%b ovf=%b"},
                                     e.cx, e.cy, e.rad, e.coll, e.ovf, o_center_x,
                                     o_center_y, o_circle_radius, o_collinear, o_overflow);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= quiet || ($urandom_range(99) >= 16);
            end
        end
    end

    // Offers one request and waits until it is taken; may then idle for a few cycles.
    task automatic send_triple(input logic signed [COORD_W-1:0] x1, y1, x2, y2, x3, y3);
        push       <= 1'b1;
        i_first_x  <= x1;
        i_first_y  <= y1;
        i_second_x <= x2;
        i_second_y <= y2;
        i_third_x  <= x3;
        i_third_y  <= y3;
        do @(posedge i_clk); while (full);
        circles_due.push_back(predict_circle(x1, y1, x2, y2, x3, y3, thr_copy));
        if (!quiet && $urandom_range(99) < 16) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Lets every outstanding result drain, then idles on for safety.
    task automatic drain_all();
        push <= 1'b0;
        @(posedge i_clk);
        while (circles_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_COLL_THR, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        thr_copy = value[15:0];
    endtask

    // Random coordinate of a chosen spread; small spreads keep most circles in range.
    function automatic logic signed [COORD_W-1:0] rand_coord(input int spread);
        logic signed [31:0] v;
        if (spread >= COORD_W) begin
            v = $urandom;
            return v[COORD_W-1:0];
        end
        v = $signed($urandom_range((1 << (spread + 1)) - 1)) - (1 << spread);
        return v[COORD_W-1:0];
    endfunction

    // Extremes of the coordinate range, coincident and collinear points, overflow.
    task automatic test_directed();
        logic signed [COORD_W-1:0] mx, mn;
        mx = C_MAX[COORD_W-1:0];
        mn = C_MIN[COORD_W-1:0];
        send_triple(0, 0, 256, 0, 0, 256);
        send_triple(mn, mn, mn, mn, mn, mn);
        send_triple(mx, mx, mx, mx, mx, mx);
        send_triple(mn, mn, mx, mx, 0, 0);
        send_triple(mn, mn, mx, mn, mn, mx);
        send_triple(mx, mx, mn, mx, mx, mn);
        send_triple(mn, mx, mx, mn, mx, mx);
        send_triple(mn, 0, mx, 0, 0, 1);
        send_triple(0, 0, 1, 0, 0, 1);
        send_triple(0, 0, 1, 1, 2, 2);
        send_triple(-1, -1, 1, 0, 0, 1);
        send_triple(100, 100, 200, 100, 100, 200);
        send_triple(0, 0, 1000, 0, 2000, 1);
        send_triple(mx, 0, mn, 0, 0, mx);
        send_triple(0, mn, 0, mx, mx, 0);
        drain_all();
    endtask

    // Mix of ordinary triangles, near-collinear triples and full-range noise.
    task automatic test_random(input int count);
        logic signed [COORD_W-1:0] x1, y1, x2, y2, x3, y3;
        int sp, kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            sp = $urandom_range(2, COORD_W);
            x1 = rand_coord(sp); y1 = rand_coord(sp);
            x2 = rand_coord(sp); y2 = rand_coord(sp);
            if (kind < 3) begin
                // Third point on the line through the first two, nudged by a few LSBs.
                x3 = COORD_W'(x1 + 2 * (x2 - x1) + rand_coord(2));
                y3 = COORD_W'(y1 + 2 * (y2 - y1) + rand_coord(2));
            end else begin
                x3 = rand_coord(sp); y3 = rand_coord(sp);
            end
            send_triple(x1, y1, x2, y2, x3, y3);
        end
    endtask

    // The result side stalls for a long stretch while requests keep coming, so the
    // block fills and holds off its input.
    task automatic test_backpressure();
        quiet = 1'b1;
        hold_req = 1'b1;
        test_random(200);
        quiet = 1'b0;
        drain_all();
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0; pop = 1'b0;
        i_first_x = '0; i_first_y = '0; i_second_x = '0;
        i_second_y = '0; i_third_x = '0; i_third_y = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        thr_copy = THR_RESET;
        mismatches = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_threshold(32'd0);
        test_directed();
        write_threshold(32'hFFFF);
        test_directed();
        test_random(110);
        drain_all();
        test_backpressure();
        write_threshold(32'h1234_0001);
        // A long stretch with no idling on either side.
        quiet = 1'b1;
        test_random(300);
        quiet = 1'b0;
        test_random(300);
        drain_all();
        for (int k = 0; k < 4; k++) begin
            write_threshold($urandom);
            test_random(200);
            drain_all();
        end
        drain_all();

        if (mismatches == 0 && circles_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
